FILE: rtl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 stream transcoder
package u8u16_pkg;

    localparam int unsigned PointWidth = 21;
    localparam int unsigned UnitWidth  = 16;

    localparam logic [PointWidth-1:0] MaxPoint   = 21'h10FFFF;
    localparam logic [PointWidth-1:0] MaxBmp     = 21'h00FFFF;
    localparam logic [PointWidth-1:0] PlaneBase  = 21'h010000;
    localparam logic [PointWidth-1:0] LineFeed   = 21'h00000A;
    localparam logic [UnitWidth-1:0]  UnitCr     = 16'h000D;
    localparam logic [UnitWidth-1:0]  UnitLf     = 16'h000A;
    localparam logic [UnitWidth-1:0]  HighSurr   = 16'hD800;
    localparam logic [UnitWidth-1:0]  LowSurr    = 16'hDC00;
    localparam logic [UnitWidth-1:0]  UnitTerm   = 16'h0000;

    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;

    // up to three units produced by one item; a terminator is always the last one
    typedef struct packed {
        logic [1:0]           count;
        logic                 term;
        logic [UnitWidth-1:0] unit0;
        logic [UnitWidth-1:0] unit1;
    } bundle_t;

endpackage

FILE: rtl/u8u16_decode.sv
// byte decoder: sequence state, code point assembly and unit bundle register
module u8u16_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_byte_present,
    input  logic                s_string_end,
    output logic                a_valid,
    output u8u16_pkg::bundle_t  a_bundle,
    input  logic                a_take
);

    logic [u8u16_pkg::PointWidth-1:0] pend_reg, pend_next;
    logic [1:0]                       rem_reg, rem_next;
    logic                             a_full_reg;
    u8u16_pkg::bundle_t               a_bundle_reg, bundle_next;

    logic                             s_fire;
    logic                             fire;
    logic [u8u16_pkg::PointWidth-1:0] cp;
    logic [u8u16_pkg::PointWidth-1:0] shifted;
    logic [u8u16_pkg::PointWidth-1:0] offs;
    logic [u8u16_pkg::UnitWidth-1:0]  pu0, pu1;
    logic [1:0]                       pn;

    assign s_ready  = !a_full_reg || a_take;
    assign s_fire   = s_valid && s_ready;
    assign a_valid  = a_full_reg;
    assign a_bundle = a_bundle_reg;

    assign shifted = {pend_reg[u8u16_pkg::PointWidth-7:0], s_in_byte[5:0]};
    assign offs    = cp - u8u16_pkg::PlaneBase;

    // sequence state and point assembly
    always_comb begin
        pend_next = pend_reg;
        rem_next  = rem_reg;
        fire      = 1'b0;
        cp        = '0;
        if (s_byte_present) begin
            if (rem_reg == 2'd0) begin
                if (!s_in_byte[7]) begin
                    fire = 1'b1;
                    cp   = {13'b0, s_in_byte};
                end else if ((s_in_byte & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Code) begin
                    pend_next = {16'b0, s_in_byte[4:0]};
                    rem_next  = 2'd1;
                end else if ((s_in_byte & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Code) begin
                    pend_next = {17'b0, s_in_byte[3:0]};
                    rem_next  = 2'd2;
                end else if ((s_in_byte & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Code) begin
                    pend_next = {18'b0, s_in_byte[2:0]};
                    rem_next  = 2'd3;
                end
            end else begin
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1) begin
                    fire      = 1'b1;
                    cp        = shifted;
                    pend_next = '0;
                end else begin
                    pend_next = shifted;
                end
            end
        end
        if (s_string_end) begin
            pend_next = '0;
            rem_next  = 2'd0;
        end
    end

    // units for the decoded point, then the terminator
    always_comb begin
        pu0 = '0;
        pu1 = '0;
        pn  = 2'd0;
        if (fire) begin
            if (cp == u8u16_pkg::LineFeed) begin
                pu0 = u8u16_pkg::UnitCr;
                pu1 = u8u16_pkg::UnitLf;
                pn  = 2'd2;
            end else if (cp <= u8u16_pkg::MaxBmp) begin
                pu0 = cp[u8u16_pkg::UnitWidth-1:0];
                pn  = 2'd1;
            end else if (cp <= u8u16_pkg::MaxPoint) begin
                pu0 = u8u16_pkg::HighSurr | {6'b0, offs[19:10]};
                pu1 = u8u16_pkg::LowSurr | {6'b0, offs[9:0]};
                pn  = 2'd2;
            end
        end
        bundle_next.unit0 = pu0;
        bundle_next.unit1 = pu1;
        bundle_next.term  = s_string_end;
        bundle_next.count = s_string_end ? pn + 2'd1 : pn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            rem_reg    <= 2'd0;
            a_full_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                pend_reg <= pend_next;
                rem_reg  <= rem_next;
            end
            if (s_fire && bundle_next.count != 2'd0) begin
                a_full_reg <= 1'b1;
            end else if (a_take) begin
                a_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && bundle_next.count != 2'd0) begin
            a_bundle_reg <= bundle_next;
        end
    end

endmodule

FILE: rtl/u8u16_emit.sv
// result register: sends the units of one bundle, one per handshake
module u8u16_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                a_valid,
    input  u8u16_pkg::bundle_t  a_bundle,
    output logic                a_take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_code_unit,
    output logic                m_is_terminator,
    output logic                m_run_last
);

    u8u16_pkg::bundle_t b_bundle_reg;
    logic               b_full_reg;
    logic [1:0]         idx_reg;
    logic               last;
    logic               m_fire;
    logic               b_free;

    assign last    = idx_reg == (b_bundle_reg.count - 2'd1);
    assign m_fire  = m_valid && m_ready;
    assign b_free  = !b_full_reg || (m_fire && last);
    assign a_take  = a_valid && b_free;
    assign m_valid = b_full_reg;

    always_comb begin
        case (idx_reg)
            2'd0:    m_code_unit = b_bundle_reg.unit0;
            2'd1:    m_code_unit = b_bundle_reg.unit1;
            default: m_code_unit = u8u16_pkg::UnitTerm;
        endcase
    end

    assign m_is_terminator = b_bundle_reg.term && last;
    assign m_run_last      = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_full_reg <= 1'b0;
            idx_reg    <= 2'd0;
        end else begin
            if (a_take) begin
                b_full_reg <= 1'b1;
                idx_reg    <= 2'd0;
            end else if (m_fire && last) begin
                b_full_reg <= 1'b0;
            end else if (m_fire) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take) begin
            b_bundle_reg <= a_bundle;
        end
    end

endmodule

FILE: rtl/utf8_to_utf16_crlf_stream.sv
// top level of the utf-8 to utf-16 stream transcoder with line feed expansion
//
// input channel (s_): one utf-8 byte per item with byte_present and string_end
// flags; string_end with no byte closes a string with only the terminator.
// result channel (m_): one utf-16 code unit per item; run_last marks the last
// unit caused by an input item, is_terminator the zero that ends a string.
// a byte yields zero to two units (cr before lf, surrogate pairs), plus the
// terminator when string_end is set, so at most three units per item.
// an accepted input passes the decode register, then the result register,
// before its first unit shows on m_.
// throughput: one byte per cycle while each byte makes at most one unit
// and m_ready stays high; a byte that makes two or three units can hold
// s_ready low while the single result register sends one unit per handshake.
// the decode register takes the next item while a result waits on m_ready;
// when both registers are full, s_ready follows the last unit's handshake.
// reset clears the open sequence and both registers; no units are pending.
module utf8_to_utf16_crlf_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_byte_present,
    input  logic        s_string_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_is_terminator,
    output logic        m_run_last
);

    logic               a_valid;
    logic               a_take;
    u8u16_pkg::bundle_t a_bundle;

    u8u16_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_byte_present (s_byte_present),
        .s_string_end   (s_string_end),
        .a_valid        (a_valid),
        .a_bundle       (a_bundle),
        .a_take         (a_take)
    );

    u8u16_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .a_valid         (a_valid),
        .a_bundle        (a_bundle),
        .a_take          (a_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_is_terminator (m_is_terminator),
        .m_run_last      (m_run_last)
    );

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_terminator |-> m_run_last && m_code_unit == u8u16_pkg::UnitTerm)
        else $error("terminator unit not last or not zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid |-> a_bundle.count != 2'd0)
        else $error("empty bundle held in decode register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid && a_bundle.term |-> a_bundle.count != 2'd0)
        else $error("terminator bundle with no units");

    assert property (@(posedge aclk) disable iff (!aresetn)
        a_take |-> ##1 m_valid)
        else $error("bundle taken but result register empty");
`endif

endmodule

FILE: tb/sv/u8u16_unit_check.sv
`timescale 1ns / 1ps
// checker for the transcoder: predicts utf-16 units from accepted bytes and compares them
module u8u16_unit_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_byte_present,
    input  logic        s_string_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_code_unit,
    input  logic        m_is_terminator,
    input  logic        m_run_last,
    output int          fail_count,
    output int          units_pending,
    output int          units_checked,
    output int          pair_count,
    output int          crlf_count,
    output int          string_count
);

    typedef struct packed {
        logic [u8u16_pkg::UnitWidth-1:0] unit;
        logic                            term;
        logic                            last;
    } utf16_unit_t;

    utf16_unit_t                      expected_units[$];
    logic [u8u16_pkg::PointWidth-1:0] open_point;
    logic [1:0]                       bytes_left;

    function automatic void queue_unit(input logic [u8u16_pkg::UnitWidth-1:0] unit,
                                       input logic term);
        utf16_unit_t u;
        u.unit = unit;
        u.term = term;
        u.last = 1'b0;
        expected_units.push_back(u);
    endfunction

    function automatic void queue_point(input logic [u8u16_pkg::PointWidth-1:0] cp);
        logic [u8u16_pkg::PointWidth-1:0] offset;
        offset = cp - u8u16_pkg::PlaneBase;
        if (cp == u8u16_pkg::LineFeed) begin
            queue_unit(u8u16_pkg::UnitCr, 1'b0);
            crlf_count++;
        end
        if (cp <= u8u16_pkg::MaxBmp) begin
            queue_unit(cp[u8u16_pkg::UnitWidth-1:0], 1'b0);
        end else if (cp <= u8u16_pkg::MaxPoint) begin
            queue_unit(u8u16_pkg::HighSurr | {6'd0, offset[19:10]}, 1'b0);
            queue_unit(u8u16_pkg::LowSurr | {6'd0, offset[9:0]}, 1'b0);
            pair_count++;
        end
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic present,
                                         input logic at_end);
        int                               first;
        logic [u8u16_pkg::PointWidth-1:0] gathered;
        utf16_unit_t                      tail;
        first = expected_units.size();
        if (present) begin
            if (bytes_left == 2'd0) begin
                if (!b[7]) begin
                    queue_point({13'd0, b});
                end else if ((b & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Code) begin
                    open_point = {16'd0, b[4:0]};
                    bytes_left = 2'd1;
                end else if ((b & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Code) begin
                    open_point = {17'd0, b[3:0]};
                    bytes_left = 2'd2;
                end else if ((b & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Code) begin
                    open_point = {18'd0, b[2:0]};
                    bytes_left = 2'd3;
                end
            end else begin
                // continuation bits are taken whatever the top two bits hold
                gathered = {open_point[14:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 2'd0) begin
                    queue_point(gathered);
                    open_point = '0;
                end else begin
                    open_point = gathered;
                end
            end
        end
        if (at_end) begin
            open_point = '0;
            bytes_left = 2'd0;
            queue_unit(u8u16_pkg::UnitTerm, 1'b1);
            string_count++;
        end
        if (expected_units.size() > first) begin
            tail = expected_units.pop_back();
            tail.last = 1'b1;
            expected_units.push_back(tail);
        end
    endfunction

    always @(posedge aclk) begin : watch
        utf16_unit_t want;
        if (!aresetn) begin
            expected_units.delete();
            open_point = '0;
            bytes_left = 2'd0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual unit %h term %b last %b",
                             $time, m_code_unit, m_is_terminator, m_run_last);
                    fail_count++;
                end else begin
                    want = expected_units.pop_front();
                    units_checked++;
                    if (m_code_unit !== want.unit) begin
                        $display("%0t: code_unit expected %h actual %h",
                                 $time, want.unit, m_code_unit);
                        fail_count++;
                    end
                    if (m_is_terminator !== want.term) begin
                        $display("%0t: is_terminator expected %b actual %b",
                                 $time, want.term, m_is_terminator);
                        fail_count++;
                    end
                    if (m_run_last !== want.last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, m_run_last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_item(s_in_byte, s_byte_present, s_string_end);
            end
        end
        units_pending = expected_units.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the transcoder: byte stimulus, receiver pacing, watchdog and verdict
module tb_top;

    localparam int unsigned RandomItems = 470;
    localparam int unsigned IdlePercent = 38;
    localparam int unsigned HoldCycles  = 120;
    localparam int unsigned StallLimit  = 4000;
    localparam int unsigned TailCycles  = 16;

    typedef enum int {EndNone, EndOnByte, EndAlone} end_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_byte_present;
    logic        s_string_end;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_code_unit;
    logic        m_is_terminator;
    logic        m_run_last;

    logic       tx_idle_on = 1'b1;
    logic       rx_idle_on = 1'b1;
    int         hold_requests = 0;
    int         holds_done = 0;
    int         hold_left = 0;
    int         items_sent = 0;
    int         stall_cycles = 0;
    int         fail_count;
    int         units_pending;
    int         units_checked;
    int         pair_count;
    int         crlf_count;
    int         string_count;
    logic [7:0] string_bytes[$];

    utf8_to_utf16_crlf_stream dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_byte_present  (s_byte_present),
        .s_string_end    (s_string_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_is_terminator (m_is_terminator),
        .m_run_last      (m_run_last)
    );

    u8u16_unit_check u_unit_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_byte_present  (s_byte_present),
        .s_string_end    (s_string_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_unit     (m_code_unit),
        .m_is_terminator (m_is_terminator),
        .m_run_last      (m_run_last),
        .fail_count      (fail_count),
        .units_pending   (units_pending),
        .units_checked   (units_checked),
        .pair_count      (pair_count),
        .crlf_count      (crlf_count),
        .string_count    (string_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver pacing, with a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(0, 99) < IdlePercent);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("tb: watchdog expired at %0t with %0d units outstanding",
                     $time, units_pending);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic at_end);
        while (tx_idle_on && $urandom_range(0, 99) < IdlePercent) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'($urandom_range(0, 255));
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_byte_present <= present;
        s_string_end <= at_end;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (present || at_end) begin
            items_sent++;
        end
    endtask

    task automatic send_queued(input end_mode_t mode);
        logic [7:0] b;
        while (string_bytes.size() > 0) begin
            b = string_bytes.pop_front();
            send_item(b, 1'b1, mode == EndOnByte && string_bytes.size() == 0);
        end
        if (mode == EndAlone) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic void queue_bytes(input logic [31:0] value, input int count);
        int i;
        for (i = count - 1; i >= 0; i--) begin
            string_bytes.push_back(value[8*i +: 8]);
        end
    endfunction

    // one character: mostly well formed, some truncated or raw noise
    function automatic void add_random_char();
        logic [20:0] cp;
        logic [7:0]  lead;
        logic [5:0]  bits;
        int          len;
        int          keep;
        int          pick;
        int          k;
        pick = $urandom_range(0, 99);
        cp = 21'($urandom_range(0, 21'h1FFFFF));
        if (pick >= 93) begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 25) begin
            len = 1;
            cp = ($urandom_range(0, 99) < 15) ? 21'h00000A : {14'd0, cp[6:0]};
        end else if (pick < 45) begin
            len = 2;
            cp[20:11] = '0;
        end else if (pick < 65) begin
            len = 3;
            cp[20:16] = '0;
            if ($urandom_range(0, 9) == 0) begin
                cp[15:11] = 5'b11011;
            end
        end else if (pick < 85) begin
            len = 4;
            if ($urandom_range(0, 4) != 0) begin
                cp = 21'h010000 + 21'($urandom_range(0, 20'hFFFFF));
            end
        end else begin
            len = $urandom_range(2, 4);
        end
        keep = (pick >= 85) ? $urandom_range(1, len - 1) : len;
        case (len)
            1: lead = {1'b0, cp[6:0]};
            2: lead = {3'b110, cp[10:6]};
            3: lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        string_bytes.push_back(lead);
        for (k = 1; k < keep; k++) begin
            bits = 6'(cp >> (6 * (len - 1 - k)));
            if ($urandom_range(0, 9) == 0) begin
                string_bytes.push_back({2'($urandom_range(0, 3)), bits});
            end else begin
                string_bytes.push_back({2'b10, bits});
            end
        end
    endfunction

    task automatic send_random_strings(input int target);
        int pick;
        while (items_sent < target) begin
            repeat ($urandom_range(1, 8)) add_random_char();
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_queued(EndOnByte);
            end else if (pick < 88) begin
                send_queued(EndAlone);
            end else begin
                send_queued(EndNone);
            end
        end
    endtask

    initial begin : stimulus
        int base;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_byte_present = 1'b0;
        s_string_end = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ascii extremes, line feed, surrogate point, largest point, out of range point,
        // stray and invalid leads, unchecked continuation
        queue_bytes(32'h00007F0A, 3);
        queue_bytes(32'h00EDA080, 3);
        queue_bytes(32'hF48FBFBF, 4);
        queue_bytes(32'hF4908080, 4);
        queue_bytes(32'h000080FF, 2);
        queue_bytes(32'h0000C241, 2);
        send_queued(EndNone);
        // end arriving in the middle of a sequence
        queue_bytes(32'h0000E282, 2);
        send_queued(EndOnByte);
        // overlong line feed with the end on the same item
        queue_bytes(32'hF080808A, 4);
        send_queued(EndOnByte);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);

        base = items_sent;
        send_random_strings(base + 120);
        // receiver stops while the sender keeps offering
        hold_requests++;
        tx_idle_on = 1'b0;
        send_random_strings(base + 170);
        s_valid <= 1'b0;
        wait (units_pending == 0);
        @(negedge aclk);
        rx_idle_on = 1'b0;
        send_random_strings(base + 320);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random_strings(base + RandomItems);

        s_valid <= 1'b0;
        wait (units_pending == 0);
        repeat (TailCycles) @(posedge aclk);
        $display("tb: %0d items sent, %0d units checked over %0d strings",
                 items_sent, units_checked, string_count);
        $display("tb: stream held %0d surrogate pairs and %0d line feed expansions",
                 pair_count, crlf_count);
        if (fail_count == 0 && units_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
